// ===== rtl/integer_amplitude_to_centibel_defines.svh =====
// Assertion macros for the amplitude-to-centibel block.
// All macros sample on clk and are disabled while rst is high.
`ifndef INTEGER_AMPLITUDE_TO_CENTIBEL_DEFINES_SVH
`define INTEGER_AMPLITUDE_TO_CENTIBEL_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define IAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define IAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IAC_ASSERT_IMP(lbl, ante, cons, msg)
`define IAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/iac_pkg.sv =====
`default_nettype none
package iac_pkg;

  localparam int AMP_W   = 32;
  localparam int LEVEL_W = 12;
  localparam int OCT_W   = 5;
  localparam int MANT_W  = 5;
  localparam int FINE_W  = 10;
  localparam int COARSE_W = 11;
  localparam int MANT_TOP = MANT_W - 1;

  // Normalized amplitude handed from the leading-one stage to the level stage.
  typedef struct packed {
    logic              invalid;
    logic [OCT_W-1:0]  octave;
    logic [MANT_W-1:0] mant;
  } norm_t;

  localparam logic signed [LEVEL_W-1:0] LEVEL_INVALID = '1;

  // (octave*301 + 2) / 5, octave 0..26; unused codes read zero.
  localparam logic [COARSE_W-1:0] COARSE_LUT [32] = '{
    11'd0,    11'd60,   11'd120,  11'd181,  11'd241,  11'd301,  11'd361,  11'd421,
    11'd482,  11'd542,  11'd602,  11'd662,  11'd722,  11'd783,  11'd843,  11'd903,
    11'd963,  11'd1023, 11'd1084, 11'd1144, 11'd1204, 11'd1264, 11'd1324, 11'd1385,
    11'd1445, 11'd1505, 11'd1565, 11'd0,    11'd0,    11'd0,    11'd0,    11'd0
  };

  // Fine correction by 5-bit mantissa.
  localparam logic signed [FINE_W-1:0] FINE_LUT [32] = '{
    -10'sd1,  10'sd0,   10'sd60,  10'sd95,  10'sd120, 10'sd140, 10'sd156, 10'sd169,
    10'sd181, 10'sd191, 10'sd200, 10'sd208, 10'sd216, 10'sd223, 10'sd229, 10'sd235,
    10'sd243, 10'sd249, 10'sd253, 10'sd258, 10'sd262, 10'sd266, 10'sd270, 10'sd274,
    10'sd278, 10'sd281, 10'sd285, 10'sd288, 10'sd291, 10'sd294, 10'sd297, 10'sd300
  };

endpackage
`default_nettype wire

// ===== rtl/iac_norm.sv =====
`default_nettype none
module iac_norm
  import iac_pkg::*;
(
  input  wire logic signed [AMP_W-1:0] amplitude,
  output norm_t                        norm
);

  logic [OCT_W-1:0]  msb;
  logic [AMP_W-2:0]  shifted;

  // priority encoder over the magnitude bits
  always_comb begin
    msb = '0;
    for (int i = 0; i < AMP_W - 1; i++) begin
      if (amplitude[i]) msb = OCT_W'(i);
    end
  end

  always_comb begin
    norm.invalid = amplitude[AMP_W-1] || (amplitude == '0);
    norm.octave  = (msb >= OCT_W'(MANT_W)) ? (msb - OCT_W'(MANT_TOP)) : '0;
    shifted      = amplitude[AMP_W-2:0] >> norm.octave;
    norm.mant    = shifted[MANT_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/iac_level.sv =====
`default_nettype none
module iac_level
  import iac_pkg::*;
(
  input  wire norm_t                     norm,
  output logic signed [LEVEL_W-1:0]      level
);

  logic signed [LEVEL_W-1:0] coarse;
  logic signed [LEVEL_W-1:0] fine;

  always_comb begin
    coarse = LEVEL_W'($signed({1'b0, COARSE_LUT[norm.octave]}));
    fine   = LEVEL_W'(FINE_LUT[norm.mant]);
    level  = norm.invalid ? LEVEL_INVALID : (coarse + fine);
  end

endmodule
`default_nettype wire

// ===== rtl/integer_amplitude_to_centibel.sv =====
//  channel   dir  handshake               payload
//  input     in   start / busy            amplitude (s32)
//  result    out  done (strobe, 1 cycle)  level_centibel (s12)
//
//  One beat accepted every cycle; busy is held low, nothing in the block
//  ever needs to refuse a beat.
//  The path runs from an input register through the leading-one /
//  table lookup / add logic to the result register.
//  rst (synchronous) clears the valid flags only; data registers float.
//  The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none
`include "integer_amplitude_to_centibel_defines.svh"
module integer_amplitude_to_centibel
  import iac_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [AMP_W-1:0]   amplitude,
  output logic                           done,
  output logic signed [LEVEL_W-1:0]      level_centibel
);

  // input stage
  logic                    in_valid;
  logic signed [AMP_W-1:0] in_amp;

  // combinational path between the two register stages
  norm_t                     norm;
  logic signed [LEVEL_W-1:0] level_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_amp <= amplitude;
  end

  // leading one -> octave and 5-bit mantissa
  iac_norm u_norm (
    .amplitude (in_amp),
    .norm      (norm)
  );

  // coarse octave table + fine mantissa table
  iac_level u_level (
    .norm  (norm),
    .level (level_next)
  );

  // result register; strobe lasts one cycle per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    level_centibel <= level_next;
  end

  // every result traces back to a beat taken through the input and result registers
  `IAC_ASSERT_IMP(a_done_has_beat, done, $past(start, 2), "result without an input beat")
  // a beat taken always sets the input-stage valid flag
  `IAC_ASSERT_NXT(a_beat_gives_stage, start && !busy, in_valid, "input beat dropped")
  // only negative level code is the invalid marker
  `IAC_ASSERT_IMP(a_neg_is_invalid, done && level_centibel[LEVEL_W-1],
                  level_centibel == LEVEL_INVALID, "negative level other than invalid code")
  // negative amplitudes give the invalid code
  `IAC_ASSERT_IMP(a_negative_input, done && $past(amplitude[AMP_W-1], 2),
                  level_centibel == LEVEL_INVALID, "negative amplitude not flagged")

endmodule
`default_nettype wire
